// ===== design/quad_batch_setup_with_texture_slots_defines.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef QUAD_BATCH_SETUP_WITH_TEXTURE_SLOTS_DEFINES_SVH
`define QUAD_BATCH_SETUP_WITH_TEXTURE_SLOTS_DEFINES_SVH
`ifndef SYNTHESIS
`define QBS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("quad batch setup check failed");
`define QBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("quad batch setup check failed");
`else
`define QBS_ASSERT_NOW(label, clk, rst, ante, cons)
`define QBS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/qbs_pkg.sv =====
package qbs_pkg;

  typedef enum logic [1:0] {
    CMD_COLOR     = 2'd0,
    CMD_TEX_WHITE = 2'd1,
    CMD_TEX_TINT  = 2'd2,
    CMD_FLUSH     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_VERT = 2'd0,
    KIND_BIND = 2'd1,
    KIND_DRAW = 2'd2
  } kind_t;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned HANDLE_W  = 32;
  localparam int unsigned SLOT_W    = 5;
  localparam int unsigned INDEX_W   = 16;
  localparam int unsigned APB_W     = 32;
  localparam int unsigned PADDR_W   = 3;

  localparam logic [INDEX_W-1:0] INDEX_STEP = 16'd6;
  localparam logic [COLOR_W-1:0] COLOR_FULL = 8'hFF;

  // Register index taken from paddr[2].
  localparam logic REG_WHITE = 1'b0;

endpackage

// ===== design/qbs_ram.sv =====
module qbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/quad_batch_setup_with_texture_slots.sv =====
// Quad batch setup with a texture slot cache. Pulse start while busy is low to
// hand over one command; busy stays high until its last result has been
// produced. Results appear on the result ports for exactly one cycle each,
// marked by strobe, with last set on the final result of the item; the
// receiver cannot stall them, so it must take every strobed result. One
// sequencer drives a single 32-bit adder and a single 32-bit comparator
// against a slot memory with registered reads. A plain colored quad is accepted,
// makes two adder passes for the far corner and then emits four vertices. A
// textured quad first compares its handle with each used slot from slot 1 up
// and takes a new slot when none matches. A flush emits a bind record for each
// bound slot and then the draw record, and an automatic flush in front of a
// quad adds those records too.
`include "quad_batch_setup_with_texture_slots_defines.svh"

module quad_batch_setup_with_texture_slots #(
  parameter int unsigned MAX_QUADS     = 8192,
  parameter int unsigned TEXTURE_SLOTS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        cmd,
  input  logic signed [qbs_pkg::COORD_W-1:0] pos_x,
  input  logic signed [qbs_pkg::COORD_W-1:0] pos_y,
  input  logic signed [qbs_pkg::COORD_W-1:0] size_x,
  input  logic signed [qbs_pkg::COORD_W-1:0] size_y,
  input  logic [qbs_pkg::COLOR_W-1:0]       in_red,
  input  logic [qbs_pkg::COLOR_W-1:0]       in_green,
  input  logic [qbs_pkg::COLOR_W-1:0]       in_blue,
  input  logic [qbs_pkg::COLOR_W-1:0]       in_alpha,
  input  logic [qbs_pkg::HANDLE_W-1:0]      texture_handle,
  output logic                              strobe,
  output logic [1:0]                        kind,
  output logic signed [qbs_pkg::COORD_W-1:0] vert_x,
  output logic signed [qbs_pkg::COORD_W-1:0] vert_y,
  output logic                              tex_u,
  output logic                              tex_v,
  output logic [qbs_pkg::SLOT_W-1:0]        slot,
  output logic [qbs_pkg::COLOR_W-1:0]       out_red,
  output logic [qbs_pkg::COLOR_W-1:0]       out_green,
  output logic [qbs_pkg::COLOR_W-1:0]       out_blue,
  output logic [qbs_pkg::COLOR_W-1:0]       out_alpha,
  output logic [qbs_pkg::HANDLE_W-1:0]      payload,
  output logic                              last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [qbs_pkg::PADDR_W-1:0]       paddr,
  input  logic [qbs_pkg::APB_W-1:0]         pwdata,
  output logic [qbs_pkg::APB_W-1:0]         prdata,
  output logic                              pready
);

  import qbs_pkg::*;

  localparam int unsigned SW = $clog2(TEXTURE_SLOTS);
  localparam int unsigned CW = $clog2(TEXTURE_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_FULL = CW'(TEXTURE_SLOTS);
  localparam logic [INDEX_W-1:0] INDEX_LIMIT = INDEX_W'(MAX_QUADS * 6);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FL_ADDR,
    S_FL_EMIT,
    S_FL_DRAW,
    S_SR_ADDR,
    S_SR_CMP,
    S_ADD_X,
    S_ADD_Y,
    S_VERT
  } state_t;

  state_t state;

  logic [HANDLE_W-1:0] white;
  logic [CW-1:0]       slot_count;
  logic [INDEX_W-1:0]  index_count;
  logic [CW-1:0]       idx;
  logic [1:0]          vcnt;
  logic                flush_only;
  logic                textured;
  logic [SLOT_W-1:0]   quad_slot;

  logic [COORD_W-1:0]  px, py, sx, sy, sum_x, sum_y;
  logic [COLOR_W-1:0]  col_r, col_g, col_b, col_a;
  logic [HANDLE_W-1:0] handle;

  logic                accept;
  logic                in_textured;
  logic                need_flush;
  logic                cfg_write;
  logic [COORD_W-1:0]  add_a, add_b, add_sum;
  logic                handle_hit;
  logic                ram_we;
  logic [HANDLE_W-1:0] ram_rdata;

  assign accept      = start && !busy;
  assign busy        = (state != S_IDLE);
  assign in_textured = (cmd == CMD_TEX_WHITE) || (cmd == CMD_TEX_TINT);
  assign need_flush  = (index_count >= INDEX_LIMIT) ||
                       (in_textured && (slot_count >= SLOTS_FULL));

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_WHITE) ? white : '0;

  // The one adder serves the x corner and then the y corner.
  assign add_a   = (state == S_ADD_X) ? px : py;
  assign add_b   = (state == S_ADD_X) ? sx : sy;
  assign add_sum = add_a + add_b;

  assign handle_hit = (ram_rdata == handle);

  // A search that runs past the used slots allocates the next free one.
  assign ram_we = (state == S_SR_ADDR) && (idx >= slot_count);

  qbs_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (TEXTURE_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_count[SW-1:0]),
    .wdata (handle),
    .raddr (idx[SW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      strobe      <= 1'b0;
      white       <= '0;
      slot_count  <= CW'(1);
      index_count <= '0;
    end else begin
      strobe <= 1'b0;
      if (cfg_write && (paddr[2] == REG_WHITE)) begin
        white <= pwdata;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            px         <= pos_x;
            py         <= pos_y;
            sx         <= size_x;
            sy         <= size_y;
            handle     <= texture_handle;
            textured   <= in_textured;
            quad_slot  <= '0;
            flush_only <= (cmd == CMD_FLUSH);
            if (cmd == CMD_TEX_WHITE) begin
              col_r <= COLOR_FULL;
              col_g <= COLOR_FULL;
              col_b <= COLOR_FULL;
              col_a <= COLOR_FULL;
            end else begin
              col_r <= in_red;
              col_g <= in_green;
              col_b <= in_blue;
              col_a <= in_alpha;
            end
            if ((cmd == CMD_FLUSH) || need_flush) begin
              idx   <= '0;
              state <= S_FL_ADDR;
            end else if (in_textured) begin
              idx   <= CW'(1);
              state <= S_SR_ADDR;
            end else begin
              state <= S_ADD_X;
            end
          end
        end
        S_FL_ADDR: begin
          state <= S_FL_EMIT;
        end
        S_FL_EMIT: begin
          strobe    <= 1'b1;
          kind      <= KIND_BIND;
          vert_x    <= '0;
          vert_y    <= '0;
          tex_u     <= 1'b0;
          tex_v     <= 1'b0;
          slot      <= SLOT_W'(idx);
          out_red   <= '0;
          out_green <= '0;
          out_blue  <= '0;
          out_alpha <= '0;
          payload   <= (idx == '0) ? white : ram_rdata;
          last      <= 1'b0;
          idx       <= idx + CW'(1);
          state     <= ((idx + CW'(1)) < slot_count) ? S_FL_ADDR : S_FL_DRAW;
        end
        S_FL_DRAW: begin
          strobe      <= 1'b1;
          kind        <= KIND_DRAW;
          vert_x      <= '0;
          vert_y      <= '0;
          tex_u       <= 1'b0;
          tex_v       <= 1'b0;
          slot        <= '0;
          out_red     <= '0;
          out_green   <= '0;
          out_blue    <= '0;
          out_alpha   <= '0;
          payload     <= HANDLE_W'(index_count);
          last        <= flush_only;
          index_count <= '0;
          slot_count  <= CW'(1);
          idx         <= CW'(1);
          if (flush_only) begin
            state <= S_IDLE;
          end else if (textured) begin
            state <= S_SR_ADDR;
          end else begin
            state <= S_ADD_X;
          end
        end
        S_SR_ADDR: begin
          if (idx >= slot_count) begin
            quad_slot  <= SLOT_W'(slot_count);
            slot_count <= slot_count + CW'(1);
            state      <= S_ADD_X;
          end else begin
            state <= S_SR_CMP;
          end
        end
        S_SR_CMP: begin
          if (handle_hit) begin
            quad_slot <= SLOT_W'(idx);
            state     <= S_ADD_X;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_SR_ADDR;
          end
        end
        S_ADD_X: begin
          sum_x <= add_sum;
          state <= S_ADD_Y;
        end
        S_ADD_Y: begin
          sum_y <= add_sum;
          vcnt  <= '0;
          state <= S_VERT;
        end
        S_VERT: begin
          // Corners run counterclockwise from the lower-left one.
          strobe    <= 1'b1;
          kind      <= KIND_VERT;
          vert_x    <= ((vcnt == 2'd1) || (vcnt == 2'd2)) ? sum_x : px;
          vert_y    <= vcnt[1] ? sum_y : py;
          tex_u     <= (vcnt == 2'd1) || (vcnt == 2'd2);
          tex_v     <= vcnt[1];
          slot      <= quad_slot;
          out_red   <= col_r;
          out_green <= col_g;
          out_blue  <= col_b;
          out_alpha <= col_a;
          payload   <= '0;
          last      <= (vcnt == 2'd3);
          vcnt      <= vcnt + 2'd1;
          if (vcnt == 2'd3) begin
            index_count <= index_count + INDEX_STEP;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `QBS_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `QBS_ASSERT_NOW(a_idle_only_last, clk, rst, strobe && !busy, last)
  `QBS_ASSERT_NEXT(a_vert_run, clk, rst, strobe && (kind == KIND_VERT) && !last, strobe && (kind == KIND_VERT))
  `QBS_ASSERT_NOW(a_slot_range, clk, rst, 1'b1, (slot_count != '0) && (slot_count <= SLOTS_FULL))
  `QBS_ASSERT_NOW(a_draw_clears, clk, rst, strobe && (kind == KIND_DRAW), (slot_count == CW'(1)) && (index_count == '0))

endmodule

// ===== test/quad_batch_setup_with_texture_slots_tb.sv =====
module quad_batch_setup_with_texture_slots_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qbs_pkg::*;

  localparam int MAX_QUADS     = 8192;
  localparam int TEXTURE_SLOTS = 32;
  localparam int INDEX_LIMIT   = MAX_QUADS * 6;

  typedef struct packed {
    cmd_t                cmd;
    logic [COORD_W-1:0]  px;
    logic [COORD_W-1:0]  py;
    logic [COORD_W-1:0]  sx;
    logic [COORD_W-1:0]  sy;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
    logic [COLOR_W-1:0]  alpha;
    logic [HANDLE_W-1:0] handle;
  } draw_cmd_t;

  typedef struct packed {
    kind_t               kind;
    logic [COORD_W-1:0]  vx;
    logic [COORD_W-1:0]  vy;
    logic                u;
    logic                v;
    logic [SLOT_W-1:0]   slot;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
    logic [COLOR_W-1:0]  alpha;
    logic [HANDLE_W-1:0] payload;
    logic                last;
  } batch_record_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic [1:0]                 cmd = '0;
  logic signed [COORD_W-1:0]  pos_x = '0;
  logic signed [COORD_W-1:0]  pos_y = '0;
  logic signed [COORD_W-1:0]  size_x = '0;
  logic signed [COORD_W-1:0]  size_y = '0;
  logic [COLOR_W-1:0]         in_red = '0;
  logic [COLOR_W-1:0]         in_green = '0;
  logic [COLOR_W-1:0]         in_blue = '0;
  logic [COLOR_W-1:0]         in_alpha = '0;
  logic [HANDLE_W-1:0]        texture_handle = '0;
  logic                       strobe;
  logic [1:0]                 kind;
  logic signed [COORD_W-1:0]  vert_x;
  logic signed [COORD_W-1:0]  vert_y;
  logic                       tex_u;
  logic                       tex_v;
  logic [SLOT_W-1:0]          slot;
  logic [COLOR_W-1:0]         out_red;
  logic [COLOR_W-1:0]         out_green;
  logic [COLOR_W-1:0]         out_blue;
  logic [COLOR_W-1:0]         out_alpha;
  logic [HANDLE_W-1:0]        payload;
  logic                       last;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [PADDR_W-1:0]         paddr = '0;
  logic [APB_W-1:0]           pwdata = '0;
  logic [APB_W-1:0]           prdata;
  logic                       pready;

  draw_cmd_t     draw_cmd_q[$];
  batch_record_t batch_records_q[$];

  // Mirror of the block's batch state.
  logic [HANDLE_W-1:0] white_handle = '0;
  logic [HANDLE_W-1:0] bound_handles[TEXTURE_SLOTS];
  int                  slots_used = 1;
  logic [INDEX_W-1:0]  indices_queued = '0;

  logic accepted = 1'b0;
  int   gap_left = 0;
  int   max_gap = 10;
  int   mismatches = 0;

  quad_batch_setup_with_texture_slots #(
    .MAX_QUADS(MAX_QUADS),
    .TEXTURE_SLOTS(TEXTURE_SLOTS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .size_x(size_x),
    .size_y(size_y),
    .in_red(in_red),
    .in_green(in_green),
    .in_blue(in_blue),
    .in_alpha(in_alpha),
    .texture_handle(texture_handle),
    .strobe(strobe),
    .kind(kind),
    .vert_x(vert_x),
    .vert_y(vert_y),
    .tex_u(tex_u),
    .tex_v(tex_v),
    .slot(slot),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .out_alpha(out_alpha),
    .payload(payload),
    .last(last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("quad_batch_setup_with_texture_slots: mismatch");
    $finish;
  end

  function automatic void push_record(kind_t k, logic [COORD_W-1:0] vx, logic [COORD_W-1:0] vy,
                                      logic u, logic v, logic [SLOT_W-1:0] s,
                                      logic [4*COLOR_W-1:0] rgba, logic [HANDLE_W-1:0] pl,
                                      logic is_last);
    batch_record_t rec;
    rec.kind    = k;
    rec.vx      = vx;
    rec.vy      = vy;
    rec.u       = u;
    rec.v       = v;
    rec.slot    = s;
    rec.red     = rgba[31:24];
    rec.green   = rgba[23:16];
    rec.blue    = rgba[15:8];
    rec.alpha   = rgba[7:0];
    rec.payload = pl;
    rec.last    = is_last;
    batch_records_q.push_back(rec);
  endfunction

  // A flush binds every slot in use, then closes the batch with the index count.
  function automatic void flush_batch(logic is_last);
    int i;
    for (i = 0; i < slots_used; i++) begin
      push_record(KIND_BIND, '0, '0, 1'b0, 1'b0, SLOT_W'(i), '0,
                  (i == 0) ? white_handle : bound_handles[i], 1'b0);
    end
    push_record(KIND_DRAW, '0, '0, 1'b0, 1'b0, '0, '0, {16'd0, indices_queued}, is_last);
    indices_queued = '0;
    slots_used = 1;
  endfunction

  function automatic void predict_batch_records(draw_cmd_t c);
    logic [4*COLOR_W-1:0] rgba;
    logic [SLOT_W-1:0]    s;
    logic                 textured;
    logic                 hit;
    logic [COORD_W-1:0]   far_x;
    logic [COORD_W-1:0]   far_y;
    int                   i;
    s = '0;
    hit = 1'b0;
    textured = (c.cmd == CMD_TEX_WHITE) || (c.cmd == CMD_TEX_TINT);
    if (c.cmd == CMD_FLUSH) begin
      flush_batch(1'b1);
      return;
    end
    if (c.cmd == CMD_TEX_WHITE) begin
      rgba = {4{COLOR_FULL}};
    end else begin
      rgba = {c.red, c.green, c.blue, c.alpha};
    end
    if (int'(indices_queued) >= INDEX_LIMIT || (textured && slots_used >= TEXTURE_SLOTS)) begin
      flush_batch(1'b0);
    end
    if (textured) begin
      // Slot 0 is never matched, even when the handle equals the white one.
      for (i = 1; i < slots_used; i++) begin
        if (!hit && bound_handles[i] == c.handle) begin
          s = SLOT_W'(i);
          hit = 1'b1;
        end
      end
      if (!hit && slots_used < TEXTURE_SLOTS) begin
        s = SLOT_W'(slots_used);
        bound_handles[slots_used] = c.handle;
        slots_used++;
      end
    end
    far_x = c.px + c.sx;
    far_y = c.py + c.sy;
    push_record(KIND_VERT, c.px, c.py, 1'b0, 1'b0, s, rgba, '0, 1'b0);
    push_record(KIND_VERT, far_x, c.py, 1'b1, 1'b0, s, rgba, '0, 1'b0);
    push_record(KIND_VERT, far_x, far_y, 1'b1, 1'b1, s, rgba, '0, 1'b0);
    push_record(KIND_VERT, c.px, far_y, 1'b0, 1'b1, s, rgba, '0, 1'b1);
    indices_queued = indices_queued + INDEX_STEP;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t: bad %s: got %h, wanted %h", $realtime, what, got, want);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      flag_mismatch(what, got, want);
    end
  endtask

  // Item driver: holds an item on the ports until it is taken.
  always @(negedge clk) begin
    draw_cmd_t nxt;
    logic      present;
    present = start && !accepted;
    if (!rst && !present) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (draw_cmd_q.size() > 0) begin
        nxt = draw_cmd_q.pop_front();
        cmd            <= nxt.cmd;
        pos_x          <= nxt.px;
        pos_y          <= nxt.py;
        size_x         <= nxt.sx;
        size_y         <= nxt.sy;
        in_red         <= nxt.red;
        in_green       <= nxt.green;
        in_blue        <= nxt.blue;
        in_alpha       <= nxt.alpha;
        texture_handle <= nxt.handle;
        gap_left       <= $urandom_range(0, max_gap);
        present = 1'b1;
      end
    end
    start <= present;
  end

  // Monitor: predicts on each accepted item and checks every strobed result.
  always @(posedge clk) begin
    draw_cmd_t     taken;
    batch_record_t want;
    accepted <= !rst && start && !busy;
    if (!rst && start && !busy) begin
      taken.cmd    = cmd_t'(cmd);
      taken.px     = pos_x;
      taken.py     = pos_y;
      taken.sx     = size_x;
      taken.sy     = size_y;
      taken.red    = in_red;
      taken.green  = in_green;
      taken.blue   = in_blue;
      taken.alpha  = in_alpha;
      taken.handle = texture_handle;
      predict_batch_records(taken);
    end
    if (!rst && strobe === 1'b1) begin
      if (batch_records_q.size() == 0) begin
        flag_mismatch("result with nothing pending, kind", {30'd0, kind}, '0);
      end else begin
        want = batch_records_q.pop_front();
        check_field("kind", {30'd0, kind}, {30'd0, want.kind});
        check_field("vert_x", vert_x, want.vx);
        check_field("vert_y", vert_y, want.vy);
        check_field("tex_u", {31'd0, tex_u}, {31'd0, want.u});
        check_field("tex_v", {31'd0, tex_v}, {31'd0, want.v});
        check_field("slot", {27'd0, slot}, {27'd0, want.slot});
        check_field("out_red", {24'd0, out_red}, {24'd0, want.red});
        check_field("out_green", {24'd0, out_green}, {24'd0, want.green});
        check_field("out_blue", {24'd0, out_blue}, {24'd0, want.blue});
        check_field("out_alpha", {24'd0, out_alpha}, {24'd0, want.alpha});
        check_field("payload", payload, want.payload);
        check_field("last", {31'd0, last}, {31'd0, want.last});
      end
    end
  end

  function automatic void add_cmd(cmd_t c, logic [31:0] px, logic [31:0] py, logic [31:0] sx,
                                  logic [31:0] sy, logic [31:0] rgba, logic [31:0] handle);
    draw_cmd_t item;
    item.cmd    = c;
    item.px     = px;
    item.py     = py;
    item.sx     = sx;
    item.sy     = sy;
    item.red    = rgba[31:24];
    item.green  = rgba[23:16];
    item.blue   = rgba[15:8];
    item.alpha  = rgba[7:0];
    item.handle = handle;
    draw_cmd_q.push_back(item);
  endfunction

  // Coordinates lean on the wrap-around corners a fair share of the time.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return {{16{1'b0}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_random_item(cmd_t c, logic [31:0] handle);
    add_cmd(c, rand_coord(), rand_coord(), rand_coord(), rand_coord(), $urandom, handle);
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (draw_cmd_q.size() != 0 || start || busy || batch_records_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_white(logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_WHITE, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    white_handle = value;
  endtask

  initial begin
    logic [31:0] handle_pool[40];
    int          pool_n;
    int          phase;
    int          phase_items;
    int          n;
    int          i;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed part, white handle still at its reset value of zero.
    add_cmd(CMD_FLUSH, '0, '0, '0, '0, '0, '0);
    add_cmd(CMD_COLOR, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'hFFFF_FFFF, $urandom);
    add_cmd(CMD_COLOR, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
            32'h0000_0000, $urandom);
    add_cmd(CMD_TEX_WHITE, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h0000_4000,
            32'h1234_5678, 32'h0000_0000);
    add_cmd(CMD_TEX_TINT, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
            32'h807F_01FE, 32'hFFFF_FFFF);
    add_cmd(CMD_TEX_TINT, $urandom, $urandom, $urandom, $urandom, $urandom, 32'h0000_0000);
    add_cmd(CMD_TEX_WHITE, $urandom, $urandom, $urandom, $urandom, $urandom, 32'hFFFF_FFFF);
    add_cmd(CMD_FLUSH, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    wait_idle();
    write_white(32'hFFFF_FFFF);
    add_cmd(CMD_TEX_WHITE, '0, '0, 32'h0001_0000, 32'h0001_0000, $urandom, 32'hFFFF_FFFF);
    add_cmd(CMD_COLOR, '0, '0, '0, '0, '0, '0);
    add_cmd(CMD_FLUSH, '0, '0, '0, '0, '0, '0);
    add_cmd(CMD_FLUSH, '0, '0, '0, '0, '0, '0);

    // Distinct textures until the slot table is full; the last one forces a flush.
    for (i = 0; i < TEXTURE_SLOTS; i++) begin
      add_random_item(($urandom_range(0, 1) == 0) ? CMD_TEX_WHITE : CMD_TEX_TINT, $urandom);
    end
    add_cmd(CMD_FLUSH, '0, '0, '0, '0, '0, '0);

    for (phase = 0; phase < 4; phase++) begin
      wait_idle();
      case (phase)
        1: write_white(32'h0000_0000);
        2: write_white(32'hFFFF_FFFF);
        default: write_white($urandom);
      endcase
      max_gap = (phase == 2) ? 0 : 10;
      pool_n = $urandom_range(4, 40);
      for (i = 0; i < 40; i++) begin
        case ($urandom_range(0, 9))
          0: handle_pool[i] = white_handle;
          1: handle_pool[i] = 32'h0000_0000;
          2: handle_pool[i] = 32'hFFFF_FFFF;
          default: handle_pool[i] = $urandom;
        endcase
      end
      phase_items = 0;
      while (phase_items < 80) begin
        if ($urandom_range(0, 9) < 8) begin
          // A well-formed batch drawn from a shared set of textures.
          n = $urandom_range(1, 40);
          repeat (n) begin
            add_random_item(cmd_t'($urandom_range(0, 2)),
                            handle_pool[$urandom_range(0, pool_n - 1)]);
          end
          if ($urandom_range(0, 1) == 1) begin
            add_random_item(CMD_FLUSH, $urandom);
            n++;
          end
        end else begin
          n = $urandom_range(1, 3);
          repeat (n) add_random_item(cmd_t'($urandom_range(0, 3)), $urandom);
        end
        phase_items += n;
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("quad_batch_setup_with_texture_slots: match");
    end else begin
      $display("quad_batch_setup_with_texture_slots: mismatch");
    end
    $finish;
  end

endmodule
